// ===== design/ape_pkg.sv =====
// ----------------------------------------------------------------------------
// ARP probe engine package
// Shared types, codes and request byte helpers for the probe engine.
// ----------------------------------------------------------------------------
package ape_pkg;

  localparam int unsigned HdrLen = 28;
  localparam logic [4:0] LastIdx = 5'(HdrLen - 1);
  localparam logic [4:0] HdrLenW = 5'(HdrLen);

  // Input operation codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Highest frame kind that is addressed to us (host, broadcast, multicast)
  localparam logic [2:0] KIND_LAST_OK = 3'd2;

  localparam logic [15:0] HW_ETHERNET = 16'd1;
  localparam logic [15:0] HW_FDDI     = 16'd8;

  // Configuration register indexes
  localparam logic [2:0] REG_OWN_IP        = 3'd0;
  localparam logic [2:0] REG_OWN_MAC       = 3'd1;
  localparam logic [2:0] REG_TARGET_IP     = 3'd2;
  localparam logic [2:0] REG_ATTEMPT_LIMIT = 3'd3;
  localparam logic [2:0] REG_DAD_MODE      = 3'd4;
  localparam logic [2:0] REG_LINK_HW_TYPE  = 3'd5;
  localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd6;

  typedef struct packed {
    logic [31:0] own_ip;
    logic [47:0] own_mac;
    logic [31:0] target_ip;
    logic [7:0]  attempt_limit;
    logic        dad_mode;
    logic [15:0] link_hw_type;
    logic [23:0] timeout_ticks;
  } cfg_t;

  // Command from the front to the back: a full request or a verdict
  typedef struct packed {
    logic verdict;
    logic found;
  } cmd_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       found;
  } result_t;

  function automatic logic [7:0] mac_byte(logic [47:0] mac, logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = mac[47:40];
      3'd1:    r = mac[39:32];
      3'd2:    r = mac[31:24];
      3'd3:    r = mac[23:16];
      3'd4:    r = mac[15:8];
      3'd5:    r = mac[7:0];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ip_byte(logic [31:0] ip, logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0:    r = ip[31:24];
      2'd1:    r = ip[23:16];
      2'd2:    r = ip[15:8];
      default: r = ip[7:0];
    endcase
    return r;
  endfunction

  // Byte idx of the outgoing ARP request
  function automatic logic [7:0] req_byte(logic [4:0] idx, cfg_t cfg);
    logic [7:0] r;
    case (idx)
      5'd0:    r = 8'h00;
      5'd1:    r = 8'h01;
      5'd2:    r = 8'h08;
      5'd3:    r = 8'h00;
      5'd4:    r = 8'd6;
      5'd5:    r = 8'd4;
      5'd6:    r = 8'h00;
      5'd7:    r = 8'h01;
      default: begin
        if (idx < 5'd14) begin
          r = mac_byte(cfg.own_mac, 3'(idx - 5'd8));
        end else if (idx < 5'd18) begin
          r = ip_byte(cfg.own_ip, 2'(idx - 5'd14));
        end else if (idx < 5'd24) begin
          r = 8'hFF;
        end else begin
          r = ip_byte(cfg.target_ip, 2'(idx - 5'd24));
        end
      end
    endcase
    return r;
  endfunction

endpackage

// ===== design/ape_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// ARP probe command queue
// Two-entry queue that decouples the front classifier from the back sender.
// ----------------------------------------------------------------------------
module ape_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ape_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ape_pkg::cmd_t cmd_o
);
  import ape_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ===== design/ape_front.sv =====
// ----------------------------------------------------------------------------
// ARP probe front end
// Accepts operations, tracks attempts, timer and the received frame, and
// issues request or verdict commands.
// ----------------------------------------------------------------------------
module ape_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ape_pkg::cfg_t cfg_i,
  input  logic          accept_i,
  input  logic [1:0]    operation_i,
  input  logic [7:0]    rx_byte_i,
  input  logic          rx_last_i,
  input  logic [2:0]    rx_frame_kind_i,
  output logic          cmd_push_o,
  output ape_pkg::cmd_t cmd_o
);
  import ape_pkg::*;

  localparam logic PH_IDLE = 1'b0;
  localparam logic PH_WAIT = 1'b1;

  // Running per-field compare results of the frame being received
  typedef struct packed {
    logic hrd_link;
    logic hrd_one;
    logic fixed;
    logic sha_eq;
    logic spa;
    logic tha;
    logic tpa;
  } match_t;

  logic        phase_q, phase_d;
  logic [7:0]  attempts_q, attempts_d;
  logic [23:0] timer_q, timer_d;
  logic [4:0]  pos_q, pos_d;
  logic        kind_ok_q, kind_ok_d;
  match_t      flags_q, flags_d;

  logic [7:0]  b;
  logic        frame_ok;
  logic        do_send, do_verdict, verdict_found, do_fail;
  logic [7:0]  att_dec;

  assign b = rx_byte_i;

  // Fold the current byte into the compare flags
  always_comb begin
    flags_d   = (pos_q == 5'd0) ? '1 : flags_q;
    kind_ok_d = (pos_q == 5'd0) ? (rx_frame_kind_i <= KIND_LAST_OK) : kind_ok_q;
    case (pos_q)
      5'd0: begin
        flags_d.hrd_link = flags_d.hrd_link & (b == cfg_i.link_hw_type[15:8]);
        flags_d.hrd_one  = flags_d.hrd_one & (b == HW_ETHERNET[15:8]);
      end
      5'd1: begin
        flags_d.hrd_link = flags_d.hrd_link & (b == cfg_i.link_hw_type[7:0]);
        flags_d.hrd_one  = flags_d.hrd_one & (b == HW_ETHERNET[7:0]);
      end
      5'd2: flags_d.fixed = flags_d.fixed & (b == 8'h08);
      5'd3: flags_d.fixed = flags_d.fixed & (b == 8'h00);
      5'd4: flags_d.fixed = flags_d.fixed & (b == 8'd6);
      5'd5: flags_d.fixed = flags_d.fixed & (b == 8'd4);
      5'd6: flags_d.fixed = flags_d.fixed & (b == 8'h00);
      5'd7: flags_d.fixed = flags_d.fixed & ((b == 8'd1) || (b == 8'd2));
      default: begin
        if (pos_q < 5'd14) begin
          flags_d.sha_eq = flags_d.sha_eq &
                           (b == mac_byte(cfg_i.own_mac, 3'(pos_q - 5'd8)));
        end else if (pos_q < 5'd18) begin
          flags_d.spa = flags_d.spa &
                        (b == ip_byte(cfg_i.target_ip, 2'(pos_q - 5'd14)));
        end else if (pos_q < 5'd24) begin
          flags_d.tha = flags_d.tha &
                        (b == mac_byte(cfg_i.own_mac, 3'(pos_q - 5'd18)));
        end else if (pos_q < HdrLenW) begin
          flags_d.tpa = flags_d.tpa &
                        (b == ip_byte(cfg_i.own_ip, 2'(pos_q - 5'd24)));
        end else begin
          // past the header: hold the flags
          flags_d = flags_q;
        end
      end
    endcase
  end

  always_comb begin
    frame_ok = kind_ok_d && flags_d.fixed && flags_d.spa &&
               (flags_d.hrd_link || ((cfg_i.link_hw_type == HW_FDDI) && flags_d.hrd_one));
    if (cfg_i.dad_mode) begin
      frame_ok = frame_ok && !flags_d.sha_eq &&
                 ((cfg_i.own_ip == 32'd0) || flags_d.tpa);
    end else begin
      frame_ok = frame_ok && flags_d.tpa && flags_d.tha;
    end
  end

  always_comb begin
    phase_d       = phase_q;
    attempts_d    = attempts_q;
    timer_d       = timer_q;
    pos_d         = pos_q;
    do_send       = 1'b0;
    do_verdict    = 1'b0;
    verdict_found = 1'b0;
    do_fail       = 1'b0;
    att_dec       = (attempts_q != 8'd0) ? attempts_q - 8'd1 : attempts_q;

    if (accept_i) begin
      case (operation_i)
        OP_START: begin
          attempts_d = cfg_i.attempt_limit;
          if (cfg_i.attempt_limit == 8'd0) begin
            do_verdict = 1'b1;
          end else begin
            do_send = 1'b1;
          end
        end
        OP_BYTE: begin
          if (phase_q == PH_WAIT) begin
            if (pos_q < HdrLenW) begin
              pos_d = pos_q + 5'd1;
            end
            if (rx_last_i) begin
              if ((pos_q >= LastIdx) && frame_ok) begin
                do_verdict    = 1'b1;
                verdict_found = 1'b1;
              end else begin
                do_fail = 1'b1;
              end
            end
          end
        end
        OP_TICK: begin
          if (phase_q == PH_WAIT) begin
            if (timer_q > 24'd1) begin
              timer_d = timer_q - 24'd1;
            end else begin
              do_fail = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    if (do_fail) begin
      attempts_d = att_dec;
      if (att_dec == 8'd0) begin
        do_verdict = 1'b1;
      end else begin
        do_send = 1'b1;
      end
    end

    if (do_send) begin
      phase_d = PH_WAIT;
      timer_d = cfg_i.timeout_ticks;
      pos_d   = 5'd0;
    end else if (do_verdict) begin
      phase_d = PH_IDLE;
      timer_d = 24'd0;
      pos_d   = 5'd0;
    end
  end

  assign cmd_push_o    = do_send || do_verdict;
  assign cmd_o.verdict = do_verdict;
  assign cmd_o.found   = verdict_found;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      attempts_q <= 8'd0;
      timer_q    <= 24'd0;
      pos_q      <= 5'd0;
      kind_ok_q  <= 1'b0;
      flags_q    <= '0;
    end else begin
      phase_q    <= phase_d;
      attempts_q <= attempts_d;
      timer_q    <= timer_d;
      pos_q      <= pos_d;
      if (accept_i && (operation_i == OP_BYTE) && (phase_q == PH_WAIT)) begin
        kind_ok_q <= kind_ok_d;
        flags_q   <= flags_d;
      end
    end
  end

endmodule

// ===== design/ape_back.sv =====
// ----------------------------------------------------------------------------
// ARP probe back end
// Turns commands into request byte runs or verdicts and queues the results.
// ----------------------------------------------------------------------------
module ape_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ape_pkg::cfg_t    cfg_i,
  input  logic             cmd_valid_i,
  input  ape_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output ape_pkg::result_t res_o
);
  import ape_pkg::*;

  logic       busy_q, busy_d;
  logic [4:0] idx_q, idx_d;

  result_t    mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       can_push, do_push, do_pop;
  result_t    res_d;

  assign empty_o  = (cnt_q == 2'd0);
  assign res_o    = mem_q[rd_q];
  assign do_pop   = pop_i && !empty_o;
  assign can_push = (cnt_q != 2'd2) || do_pop;

  always_comb begin
    busy_d    = busy_q;
    idx_d     = idx_q;
    cmd_pop_o = 1'b0;
    do_push   = 1'b0;
    res_d     = '0;
    if (can_push) begin
      if (busy_q) begin
        do_push       = 1'b1;
        res_d.tx_byte = req_byte(idx_q, cfg_i);
        res_d.tx_last = (idx_q == LastIdx);
        idx_d         = idx_q + 5'd1;
        if (idx_q == LastIdx) begin
          busy_d = 1'b0;
        end
      end else if (cmd_valid_i) begin
        cmd_pop_o = 1'b1;
        do_push   = 1'b1;
        if (cmd_i.verdict) begin
          res_d.kind  = 1'b1;
          res_d.found = cmd_i.found;
        end else begin
          // first request byte now, the rest from the counter
          res_d.tx_byte = req_byte(5'd0, cfg_i);
          idx_d         = 5'd1;
          busy_d        = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 5'd0;
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= res_d;
    end
  end

endmodule

// ===== design/arp_probe_engine_unit.sv =====
// ----------------------------------------------------------------------------
// ARP probe engine
// Sends ARP requests, checks received ARP frames byte by byte, retries on
// timeout or rejection and reports whether the probed address answered.
// ----------------------------------------------------------------------------
// Result path: the first result of an item passes through the command queue,
//   then the back output queue, before it reaches the result ports.
// Throughput: one input transaction per cycle while full is low; a request run
//   occupies the sender for its 28 bytes, one byte per cycle while the result queue
//   has room, so full rises once two commands wait in the command queue behind it.
// Reset: asynchronous, clears all control state and queues and loads the
//   register reset values; no clearing pass, the block is ready at once.
// ----------------------------------------------------------------------------
module arp_probe_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_last_i,
  input  logic [2:0]  rx_frame_kind_i,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic        kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        tx_last_o,
  output logic        found_o
);
  import ape_pkg::*;

  cfg_t    cfg_q;
  logic    accept;
  logic    cmd_push;
  cmd_t    cmd_in;
  logic    cmd_valid;
  cmd_t    cmd_out;
  logic    cmd_pop;
  result_t res;

  // The user must write registers only while idle; the block does not enforce it, so always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_ip        <= 32'd0;
      cfg_q.own_mac       <= 48'd0;
      cfg_q.target_ip     <= 32'd0;
      cfg_q.attempt_limit <= 8'd3;
      cfg_q.dad_mode      <= 1'b0;
      cfg_q.link_hw_type  <= HW_ETHERNET;
      cfg_q.timeout_ticks <= 24'd1000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_OWN_IP:        cfg_q.own_ip        <= cfg_data_i[31:0];
        REG_OWN_MAC:       cfg_q.own_mac       <= cfg_data_i;
        REG_TARGET_IP:     cfg_q.target_ip     <= cfg_data_i[31:0];
        REG_ATTEMPT_LIMIT: cfg_q.attempt_limit <= cfg_data_i[7:0];
        REG_DAD_MODE:      cfg_q.dad_mode      <= cfg_data_i[0];
        REG_LINK_HW_TYPE:  cfg_q.link_hw_type  <= cfg_data_i[15:0];
        REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data_i[23:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Accept a transaction only while the command queue has room, so every
  // decision of the front has a slot waiting for it.
  assign accept = push && !full;

  // Front: classify operations, track attempts, timer and frame compare.
  ape_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .accept_i        (accept),
    .operation_i     (operation_i),
    .rx_byte_i       (rx_byte_i),
    .rx_last_i       (rx_last_i),
    .rx_frame_kind_i (rx_frame_kind_i),
    .cmd_push_o      (cmd_push),
    .cmd_o           (cmd_in)
  );

  // Short queue between front and back: each side stalls on its own.
  ape_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_out)
  );

  // Back: expand a request into 28 bytes or emit a verdict.
  ape_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign kind_o    = res.kind;
  assign tx_byte_o = res.tx_byte;
  assign tx_last_o = res.tx_last;
  assign found_o   = res.found;

endmodule

// ===== sim/tb_arp_probe_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP probe engine testbench
// Feeds probe operations, received frame bytes and timer ticks into the
// engine through its queue-style port under random burst and stall traffic,
// predicts every request byte and verdict, and checks each result as it
// leaves the engine. Directed corner cases run first, then random probe
// sequences over several register settings.
// ----------------------------------------------------------------------------
module tb_arp_probe_engine_unit;
  import ape_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;   // unused operation code, ignored by the engine
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 10;

  // Ways to spoil an otherwise matching reply frame
  localparam int unsigned FLAW_NONE       = 0;
  localparam int unsigned FLAW_BIT        = 1;
  localparam int unsigned FLAW_SHORT      = 2;
  localparam int unsigned FLAW_LONG       = 3;
  localparam int unsigned FLAW_KIND       = 4;
  localparam int unsigned FLAW_OPCODE     = 5;
  localparam int unsigned FLAW_OWN_SENDER = 6;
  localparam int unsigned FLAW_HWTYPE     = 7;

  typedef enum logic {PROBE_IDLE, PROBE_WAIT} probe_state_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic       last;
    logic [2:0] fkind;
  } probe_op_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = REG_OWN_IP;
  logic [47:0] cfg_data_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  operation_i = OP_TICK;
  logic [7:0]  rx_byte_i = '0;
  logic        rx_last_i = 1'b0;
  logic [2:0]  rx_frame_kind_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        kind_o;
  logic [7:0]  tx_byte_o;
  logic        tx_last_o;
  logic        found_o;

  arp_probe_engine_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .push            (push),
    .full            (full),
    .operation_i     (operation_i),
    .rx_byte_i       (rx_byte_i),
    .rx_last_i       (rx_last_i),
    .rx_frame_kind_i (rx_frame_kind_i),
    .empty           (empty),
    .pop             (pop),
    .kind_o          (kind_o),
    .tx_byte_o       (tx_byte_o),
    .tx_last_o       (tx_last_o),
    .found_o         (found_o)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the registers and of the probe state
  // --------------------------------------------------------------------------
  cfg_t         cfg_q;
  probe_state_e probe_state = PROBE_IDLE;
  logic [7:0]   tries_left = '0;
  logic [23:0]  reply_timer = '0;
  logic [4:0]   rx_count = '0;
  logic [7:0]   rx_hdr [HdrLen];
  logic         rx_addressed = 1'b0;

  probe_op_t    probe_ops_q[$];   // operations waiting to be driven
  result_t      probe_out_q[$];   // request bytes and verdicts still to come

  int unsigned  n_queued = 0;
  int unsigned  n_accepted = 0;
  int unsigned  n_checked = 0;
  int unsigned  n_requests = 0;
  int unsigned  n_verdicts = 0;
  int unsigned  n_answered = 0;
  int unsigned  n_settings = 0;
  int unsigned  errors = 0;
  int unsigned  cycles = 0;

  function automatic void expect_result(logic k, logic [7:0] b, logic l, logic f);
    result_t r;
    r.kind    = k;
    r.tx_byte = b;
    r.tx_last = l;
    r.found   = f;
    probe_out_q.push_back(r);
  endfunction

  // Queue the 28 request bytes and arm the reply wait
  function automatic void predict_request();
    logic [7:0]  b;
    int unsigned i;
    for (i = 0; i < HdrLen; i++) begin
      if (i < 8) begin
        b = (i == 1 || i == 7) ? 8'h01 : (i == 2) ? 8'h08 :
            (i == 4) ? 8'd6 : (i == 5) ? 8'd4 : 8'h00;
      end else if (i < 14) begin
        b = cfg_q.own_mac[47 - 8 * (i - 8) -: 8];
      end else if (i < 18) begin
        b = cfg_q.own_ip[31 - 8 * (i - 14) -: 8];
      end else if (i < 24) begin
        b = 8'hFF;
      end else begin
        b = cfg_q.target_ip[31 - 8 * (i - 24) -: 8];
      end
      expect_result(1'b0, b, i == HdrLen - 1, 1'b0);
    end
    probe_state  = PROBE_WAIT;
    reply_timer  = cfg_q.timeout_ticks;
    rx_count     = '0;
    rx_addressed = 1'b0;
  endfunction

  function automatic void predict_verdict(logic f);
    expect_result(1'b1, 8'h00, 1'b0, f);
    probe_state  = PROBE_IDLE;
    reply_timer  = '0;
    rx_count     = '0;
    rx_addressed = 1'b0;
  endfunction

  // One attempt lost: resend, or give up once none are left
  function automatic void predict_retry();
    if (tries_left != 0) tries_left--;
    if (tries_left == 0) predict_verdict(1'b0);
    else predict_request();
  endfunction

  function automatic logic reply_matches();
    logic [15:0] hrd, prot, opc;
    logic [47:0] sha, tha;
    logic [31:0] spa, tpa;
    hrd  = {rx_hdr[0], rx_hdr[1]};
    prot = {rx_hdr[2], rx_hdr[3]};
    opc  = {rx_hdr[6], rx_hdr[7]};
    sha  = {rx_hdr[8], rx_hdr[9], rx_hdr[10], rx_hdr[11], rx_hdr[12], rx_hdr[13]};
    spa  = {rx_hdr[14], rx_hdr[15], rx_hdr[16], rx_hdr[17]};
    tha  = {rx_hdr[18], rx_hdr[19], rx_hdr[20], rx_hdr[21], rx_hdr[22], rx_hdr[23]};
    tpa  = {rx_hdr[24], rx_hdr[25], rx_hdr[26], rx_hdr[27]};
    if (!rx_addressed) return 1'b0;
    if (opc != 16'd1 && opc != 16'd2) return 1'b0;
    // an FDDI link also accepts Ethernet hardware type
    if (hrd != cfg_q.link_hw_type &&
        !(cfg_q.link_hw_type == HW_FDDI && hrd == HW_ETHERNET)) return 1'b0;
    if (prot != 16'h0800) return 1'b0;
    if (rx_hdr[4] != 8'd6 || rx_hdr[5] != 8'd4) return 1'b0;
    if (spa != cfg_q.target_ip) return 1'b0;
    if (!cfg_q.dad_mode) begin
      if (tpa != cfg_q.own_ip || tha != cfg_q.own_mac) return 1'b0;
    end else begin
      if (sha == cfg_q.own_mac) return 1'b0;
      if (cfg_q.own_ip != 0 && cfg_q.own_ip != tpa) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the predictor by one accepted operation
  function automatic void probe_step(probe_op_t it);
    if (it.op == OP_START) begin
      tries_left = cfg_q.attempt_limit;
      if (tries_left == 0) predict_verdict(1'b0);
      else predict_request();
    end else if (probe_state == PROBE_WAIT) begin
      if (it.op == OP_BYTE) begin
        // the frame kind of the first byte decides for the whole frame
        if (rx_count == 0) rx_addressed = (it.fkind <= KIND_LAST_OK);
        if (rx_count < HdrLenW) begin
          rx_hdr[rx_count] = it.data;
          rx_count++;
        end
        if (it.last) begin
          if (rx_count >= HdrLenW && reply_matches()) predict_verdict(1'b1);
          else predict_retry();
        end
      end else if (it.op == OP_TICK) begin
        if (reply_timer > 1) reply_timer--;
        else predict_retry();
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Clock, cycle guard
  // --------------------------------------------------------------------------
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("arp_probe_engine_unit test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver: pull operations from the pending queue in bursts with random gaps.
  // An operation counts as accepted at an edge with push high and full low;
  // predict its results right there.
  // --------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin : feed_ops
    probe_op_t cur, nxt;
    if (push && !full) begin
      cur.op    = operation_i;
      cur.data  = rx_byte_i;
      cur.last  = rx_last_i;
      cur.fkind = rx_frame_kind_i;
      probe_step(cur);
      n_accepted++;
    end
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!(push && full)) begin
      if (gap_left != 0 || probe_ops_q.size() == 0) begin
        // hold off: either in a gap or nothing left to send
        push <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        nxt = probe_ops_q.pop_front();
        push            <= 1'b1;
        operation_i     <= nxt.op;
        rx_byte_i       <= nxt.data;
        rx_last_i       <= nxt.last;
        rx_frame_kind_i <= nxt.fkind;
        if (burst_left <= 1) begin
          // new burst; about a quarter of bursts follow without any gap
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each popped result with the oldest expectation, and
  // drive pop from a stall pattern that changes each time the 6-bit stall counter wraps.
  // --------------------------------------------------------------------------
  logic [5:0] stall_cnt = '0;
  logic [1:0] stall_mode = '0;

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : watch_results
    result_t want;
    if (pop && !empty) begin
      if (probe_out_q.size() == 0) begin
        errors++;
        $display({"%0t: unexpected result, expected none, ",
                  "actual kind %0d byte %02h last %0d found %0d"},
                 $time, kind_o, tx_byte_o, tx_last_o, found_o);
      end else begin
        want = probe_out_q.pop_front();
        check_field("kind", want.kind, kind_o);
        check_field("tx_byte", want.tx_byte, tx_byte_o);
        check_field("tx_last", want.tx_last, tx_last_o);
        check_field("found", want.found, found_o);
        n_checked++;
        if (want.tx_last) n_requests++;
        if (want.kind) begin
          n_verdicts++;
          if (want.found) n_answered++;
        end
      end
    end
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt == '1) stall_mode <= 2'($urandom_range(0, 3));
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      case (stall_mode)
        2'd0:    pop <= 1'b1;                            // no stalls at all
        2'd1:    pop <= 1'($urandom_range(0, 1));        // coin toss
        2'd2:    pop <= ($urandom_range(0, 7) == 0);     // heavy back-pressure
        default: pop <= stall_cnt[2];                    // periodic on/off
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_op(logic [1:0] op, logic [7:0] data, logic last, logic [2:0] fk);
    probe_op_t it;
    it.op    = op;
    it.data  = data;
    it.last  = last;
    it.fkind = fk;
    probe_ops_q.push_back(it);
    n_queued++;
  endtask

  // Fields that the operation does not use still get random values
  task automatic queue_rand_op(logic [1:0] op);
    queue_op(op, 8'($urandom), 1'($urandom), 3'($urandom));
  endtask

  // Build a reply that matches the current settings, then spoil it as asked
  task automatic queue_frame(int unsigned flaw);
    logic [7:0]  f [36];
    logic [15:0] hw;
    logic [47:0] sha, tha;
    logic [31:0] tpa;
    logic [2:0]  fk;
    int unsigned len, i;
    hw  = (cfg_q.link_hw_type == HW_FDDI && $urandom_range(0, 1)) ? HW_ETHERNET
                                                                  : cfg_q.link_hw_type;
    sha = {16'($urandom), 32'($urandom)};
    if (sha == cfg_q.own_mac) sha[0] = ~sha[0];
    tha = cfg_q.dad_mode ? {16'($urandom), 32'($urandom)} : cfg_q.own_mac;
    tpa = (cfg_q.dad_mode && cfg_q.own_ip == 0) ? 32'($urandom) : cfg_q.own_ip;
    f[0] = hw[15:8];
    f[1] = hw[7:0];
    f[2] = 8'h08;
    f[3] = 8'h00;
    f[4] = 8'd6;
    f[5] = 8'd4;
    f[6] = 8'h00;
    f[7] = 8'($urandom_range(1, 2));
    for (i = 0; i < 6; i++) f[8 + i] = sha[47 - 8 * i -: 8];
    for (i = 0; i < 4; i++) f[14 + i] = cfg_q.target_ip[31 - 8 * i -: 8];
    for (i = 0; i < 6; i++) f[18 + i] = tha[47 - 8 * i -: 8];
    for (i = 0; i < 4; i++) f[24 + i] = tpa[31 - 8 * i -: 8];
    for (i = HdrLen; i < 36; i++) f[i] = 8'($urandom);
    len = HdrLen;
    fk  = 3'($urandom_range(0, KIND_LAST_OK));
    case (flaw)
      FLAW_BIT: begin
        i = $urandom_range(0, HdrLen - 1);
        f[i] = f[i] ^ (8'h01 << $urandom_range(0, 7));
      end
      FLAW_SHORT:  len = $urandom_range(1, HdrLen - 1);
      FLAW_LONG:   len = $urandom_range(HdrLen + 1, 36);
      FLAW_KIND:   fk = 3'($urandom_range(KIND_LAST_OK + 1, 7));
      FLAW_OPCODE: begin
        f[6] = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom);
        f[7] = 8'($urandom);
      end
      FLAW_OWN_SENDER: begin
        for (i = 0; i < 6; i++) f[8 + i] = cfg_q.own_mac[47 - 8 * i -: 8];
      end
      FLAW_HWTYPE: begin
        f[0] = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom);
        f[1] = 8'($urandom);
      end
      default: ;
    endcase
    for (i = 0; i < len; i++) begin
      queue_op(OP_BYTE, f[i], i == len - 1, (i == 0) ? fk : 3'($urandom));
    end
  endtask

  // One probe: start, then a few replies, timeouts and noise until answered
  task automatic queue_probe();
    int unsigned n_ev, k, r;
    bit          answered;
    queue_rand_op(OP_START);
    n_ev     = $urandom_range(1, 5);
    answered = 1'b0;
    for (k = 0; k < n_ev && !answered; k++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        queue_frame(FLAW_NONE);
        answered = 1'b1;
      end else if (r < 60) begin
        queue_frame($urandom_range(FLAW_BIT, FLAW_HWTYPE));
      end else if (r < 82) begin
        repeat ($urandom_range(1, 4)) queue_rand_op(OP_TICK);
      end else if (r < 88) begin
        queue_rand_op(OP_NONE);
      end else if (r < 93) begin
        queue_rand_op(OP_START);
      end else begin
        queue_rand_op(OP_BYTE);   // stray byte, maybe ending a frame early
      end
    end
  endtask

  // Wait until every operation is in and every result is out, then let the
  // engine settle before the registers change
  task automatic drain();
    do @(posedge clk_i);
    while (probe_ops_q.size() != 0 || push || probe_out_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [47:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_OWN_IP:        cfg_q.own_ip = data[31:0];
      REG_OWN_MAC:       cfg_q.own_mac = data[47:0];
      REG_TARGET_IP:     cfg_q.target_ip = data[31:0];
      REG_ATTEMPT_LIMIT: cfg_q.attempt_limit = data[7:0];
      REG_DAD_MODE:      cfg_q.dad_mode = data[0];
      REG_LINK_HW_TYPE:  cfg_q.link_hw_type = data[15:0];
      REG_TIMEOUT_TICKS: cfg_q.timeout_ticks = data[23:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [31:0] ip, logic [47:0] mac, logic [31:0] tip,
                           logic [7:0] lim, logic dad, logic [15:0] hw, logic [23:0] tmo);
    cfg_write(REG_OWN_IP, 48'(ip));
    cfg_write(REG_OWN_MAC, mac);
    cfg_write(REG_TARGET_IP, 48'(tip));
    cfg_write(REG_ATTEMPT_LIMIT, 48'(lim));
    cfg_write(REG_DAD_MODE, 48'(dad));
    cfg_write(REG_LINK_HW_TYPE, 48'(hw));
    cfg_write(REG_TIMEOUT_TICKS, 48'(tmo));
    n_settings++;
  endtask

  // Random probes for one setting; close with an answered probe so the
  // engine is idle before the next register change
  task automatic run_random_phase(int unsigned n);
    int unsigned goal;
    goal = n_queued + n;
    while (n_queued < goal) queue_probe();
    queue_rand_op(OP_START);
    queue_frame(FLAW_NONE);
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned i;
    cfg_q.own_ip        = '0;
    cfg_q.own_mac       = '0;
    cfg_q.target_ip     = '0;
    cfg_q.attempt_limit = 8'd3;
    cfg_q.dad_mode      = 1'b0;
    cfg_q.link_hw_type  = HW_ETHERNET;
    cfg_q.timeout_ticks = 24'd1000;
    for (i = 0; i < HdrLen; i++) rx_hdr[i] = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    n_settings = 1;

    // Reset registers: ignored operations, short frame, restart, give-up
    queue_op(OP_NONE, 8'hFF, 1'b1, 3'd7);      // unused code does nothing
    queue_op(OP_BYTE, 8'hA5, 1'b1, 3'd0);      // byte while idle
    queue_op(OP_TICK, 8'h00, 1'b0, 3'd0);      // tick while idle
    queue_op(OP_START, 8'h00, 1'b0, 3'd0);
    queue_op(OP_BYTE, 8'h00, 1'b0, 3'd1);      // two-byte frame, rejected
    queue_op(OP_BYTE, 8'hFF, 1'b1, 3'd2);
    queue_op(OP_TICK, 8'hFF, 1'b1, 3'd7);      // far from the timeout
    queue_op(OP_START, 8'h5A, 1'b1, 3'd4);     // restart while waiting
    queue_op(OP_BYTE, 8'h00, 1'b1, 3'd0);      // three one-byte frames use up
    queue_op(OP_BYTE, 8'hFF, 1'b1, 3'd7);      // every attempt
    queue_op(OP_BYTE, 8'h3C, 1'b1, 3'd5);
    drain();

    // Zero attempt limit: verdict at once
    cfg_write(REG_ATTEMPT_LIMIT, 48'd0);
    cfg_write(REG_TIMEOUT_TICKS, 48'd0);
    n_settings++;
    queue_op(OP_START, 8'hFF, 1'b1, 3'd7);
    drain();

    // Zero timeout behaves as one tick: each tick costs an attempt
    cfg_write(REG_ATTEMPT_LIMIT, 48'd2);
    n_settings++;
    queue_op(OP_START, 8'h00, 1'b0, 3'd0);
    queue_op(OP_TICK, 8'h00, 1'b0, 3'd0);
    queue_op(OP_TICK, 8'hFF, 1'b1, 3'd7);
    drain();

    // Random probes over several settings, extremes included
    configure(32'($urandom), {16'($urandom), 32'($urandom)}, 32'($urandom),
              8'd3, 1'b0, HW_ETHERNET, 24'd2);
    run_random_phase(20);
    configure('1, '1, '1, 8'd1, 1'b1, HW_FDDI, 24'd1);
    run_random_phase(20);
    configure('0, '0, '0, 8'd255, 1'b1, 16'hFFFF, 24'hFFFFFF);
    run_random_phase(20);
    configure(32'($urandom), {16'($urandom), 32'($urandom)}, 32'($urandom),
              8'($urandom_range(1, 4)), 1'b0, HW_FDDI, 24'd0);
    run_random_phase(20);
    configure(32'($urandom), {16'($urandom), 32'($urandom)}, 32'($urandom),
              8'd2, 1'($urandom), 16'($urandom), 24'($urandom_range(1, 5)));
    run_random_phase(20);

    $display("Drove %0d operations and frame bytes under %0d register settings.",
             n_accepted, n_settings);
    $display("Checked %0d results: %0d request runs, %0d verdicts (%0d answered).",
             n_checked, n_requests, n_verdicts, n_answered);
    if (errors == 0) begin
      $display("arp_probe_engine_unit test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("arp_probe_engine_unit test failed");
    end
    $finish;
  end

endmodule
